// ===== hdl/perlin_noise_2d_assert.svh =====
// Assertion macros used by the noise block's top-level RTL file.
`ifndef PERLIN_NOISE_2D_ASSERT_SVH
`define PERLIN_NOISE_2D_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PN2D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pn2d_pkg.sv =====
// Shared types and constants of the 2-D gradient noise block.
package pn2d_pkg;

  localparam int TABLE_SIZE      = 256;
  localparam int COORD_FRAC_BITS = 8;

  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int BANK_DEPTH = TABLE_SIZE / 2;
  localparam int BANK_AW    = IDX_W - 1;

  localparam int ENTRY_W = 8;
  localparam int COORD_W = 24;
  localparam int NOISE_W = 16;

  // Fraction and fade widths, all Q0.16 based.
  localparam int T_W        = 16;
  localparam int FADE_P_W   = T_W + 5;
  localparam int FADE_ACC_W = 2 * T_W + 5;
  localparam int U_W        = T_W + 1;

  // Gradient, difference and lerp product widths.
  localparam int OFS_W  = T_W + 1;
  localparam int GRAD_W = T_W + 3;
  localparam int DIFF_W = T_W + 4;
  localparam int M_W    = U_W + 1 + DIFF_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [ENTRY_W-1:0] entry_t;
  typedef logic signed [NOISE_W-1:0] noise_t;

  typedef enum logic {
    KIND_EVAL  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    GRAD_XPY  = 2'd0,
    GRAD_NXPY = 2'd1,
    GRAD_XNY  = 2'd2,
    GRAD_NXNY = 2'd3
  } grad_sel_t;

endpackage

// ===== hdl/pn2d_ram.sv =====
// Generic RAM: one write port, two registered read ports, read-before-write.
module pn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd0_r;
  logic [WIDTH-1:0] rd1_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd0_r <= mem_r[raddr0];
      rd1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

// ===== hdl/perlin_noise_2d.sv =====
// Top level of the 2-D gradient noise block: table memories and noise pipeline.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   in      | in_valid/in_ready, kind, x/y coord, entry    | request in
//   out     | out_valid/out_ready, noise_value             | result out
//
// One request per cycle while in_ready is high; evaluate requests leave results in order.
// Write requests update all table copies at acceptance and leave no result.
// Two copies of the table feed the two dependent lookups in successive stages.
// Reset clears only pipeline valids; the table is undefined until written.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up and new requests are taken while a finished result waits.
module perlin_noise_2d (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pn2d_pkg::kind_t   in_kind,
  input  pn2d_pkg::coord_t  in_x_coord,
  input  pn2d_pkg::coord_t  in_y_coord,
  input  pn2d_pkg::entry_t  in_entry_index,
  input  pn2d_pkg::entry_t  in_entry_value,
  output logic              out_valid,
  input  logic              out_ready,
  output pn2d_pkg::noise_t  out_noise_value
);

  import pn2d_pkg::*;

  `include "perlin_noise_2d_assert.svh"

  localparam int NST = 10;

  localparam logic signed [DIFF_W-1:0] NOISE_MAX = DIFF_W'((1 << (NOISE_W - 1)) - 1);
  localparam logic signed [DIFF_W-1:0] NOISE_MIN = -DIFF_W'(1 << (NOISE_W - 1));

  // Fade polynomial core: (6*t*t - 15*t*2^16 + 10*2^32) >> 16.
  function automatic logic [FADE_P_W-1:0] fade_p(input logic [2*T_W-1:0] tt,
                                                 input logic [T_W-1:0] t);
    logic [FADE_ACC_W-1:0] acc;
    acc = FADE_ACC_W'(tt) * FADE_ACC_W'(6)
        + (FADE_ACC_W'(10) << (2 * T_W))
        - ((FADE_ACC_W'(t) * FADE_ACC_W'(15)) << T_W);
    return acc[FADE_ACC_W-1:T_W];
  endfunction

  function automatic logic [FADE_P_W-1:0] mul_shift(input logic [T_W-1:0] t,
                                                    input logic [FADE_P_W-1:0] r);
    logic [T_W+FADE_P_W-1:0] prod;
    prod = (T_W + FADE_P_W)'(t) * (T_W + FADE_P_W)'(r);
    return prod[T_W+FADE_P_W-1:T_W];
  endfunction

  function automatic logic signed [GRAD_W-1:0] grad(input logic [ENTRY_W-1:0] h,
                                                    input logic signed [OFS_W-1:0] x,
                                                    input logic signed [OFS_W-1:0] y);
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] g;
    gx = GRAD_W'(x);
    gy = GRAD_W'(y);
    case (grad_sel_t'(h[1:0]))
      GRAD_XPY:  g = gx + gy;
      GRAD_NXPY: g = gy - gx;
      GRAD_XNY:  g = gx - gy;
      GRAD_NXNY: g = -gx - gy;
      default:   g = gx + gy;
    endcase
    return g;
  endfunction

  // ---------------- pipeline control ----------------
  logic [NST:1]   v_r;
  logic [NST:1]   v_nxt;
  logic [NST+1:1] rdy;
  logic [NST:1]   src;
  logic [NST:1]   ld;

  always_comb begin
    rdy[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    src[1] = in_valid && (in_kind == KIND_EVAL);
    for (int k = 2; k <= NST; k++) begin
      src[k] = v_r[k-1];
    end
    for (int k = 1; k <= NST; k++) begin
      ld[k]    = rdy[k] && src[k];
      v_nxt[k] = rdy[k] ? src[k] : v_r[k];
    end
  end

  assign in_ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  logic wr_en;
  logic [IDX_W-1:0] wr_idx;

  assign wr_en  = in_valid && in_ready && (in_kind == KIND_WRITE);
  assign wr_idx = IDX_W'(in_entry_index);

  // ---------------- stage 1: cell lookup ----------------
  logic [IDX_W-1:0] xcell;
  logic [IDX_W-1:0] xcell_p1;
  logic [ENTRY_W-1:0] px;
  logic [ENTRY_W-1:0] px1;

  assign xcell    = in_x_coord[COORD_FRAC_BITS +: IDX_W];
  assign xcell_p1 = xcell + IDX_W'(1);

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_cell (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_idx),
    .wdata  (in_entry_value),
    .re     (ld[1]),
    .raddr0 (xcell),
    .raddr1 (xcell_p1),
    .rdata0 (px),
    .rdata1 (px1)
  );

  logic [T_W-1:0]   xt1_r, yt1_r;
  logic [IDX_W-1:0] yc1_r;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      xt1_r <= {in_x_coord[COORD_FRAC_BITS-1:0], {(T_W - COORD_FRAC_BITS){1'b0}}};
      yt1_r <= {in_y_coord[COORD_FRAC_BITS-1:0], {(T_W - COORD_FRAC_BITS){1'b0}}};
      yc1_r <= in_y_coord[COORD_FRAC_BITS +: IDX_W];
    end
  end

  // ---------------- stage 2: corner lookup in even/odd banks ----------------
  // Corners (base) and (base + 1) always fall in opposite banks.
  logic [IDX_W-1:0] base_a, base_b, base_a_p1, base_b_p1;
  logic [ENTRY_W-1:0] ev0, ev1, od0, od1;
  logic bank_wr_even, bank_wr_odd;

  assign base_a    = IDX_W'(px) + yc1_r;
  assign base_b    = IDX_W'(px1) + yc1_r;
  assign base_a_p1 = base_a + IDX_W'(1);
  assign base_b_p1 = base_b + IDX_W'(1);

  assign bank_wr_even = wr_en && !wr_idx[0];
  assign bank_wr_odd  = wr_en && wr_idx[0];

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_ram_even (
    .clk    (clk),
    .we     (bank_wr_even),
    .waddr  (wr_idx[IDX_W-1:1]),
    .wdata  (in_entry_value),
    .re     (ld[2]),
    .raddr0 (base_a_p1[IDX_W-1:1]),
    .raddr1 (base_b_p1[IDX_W-1:1]),
    .rdata0 (ev0),
    .rdata1 (ev1)
  );

  pn2d_ram #(.WIDTH(ENTRY_W), .DEPTH(BANK_DEPTH)) u_ram_odd (
    .clk    (clk),
    .we     (bank_wr_odd),
    .waddr  (wr_idx[IDX_W-1:1]),
    .wdata  (in_entry_value),
    .re     (ld[2]),
    .raddr0 (base_a[IDX_W-1:1]),
    .raddr1 (base_b[IDX_W-1:1]),
    .rdata0 (od0),
    .rdata1 (od1)
  );

  logic sel_a2_r, sel_b2_r;
  logic [T_W-1:0]   xt2_r, yt2_r;
  logic [2*T_W-1:0] txx2_r, tyy2_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      sel_a2_r <= base_a[0];
      sel_b2_r <= base_b[0];
      xt2_r    <= xt1_r;
      yt2_r    <= yt1_r;
      txx2_r   <= (2 * T_W)'(xt1_r) * (2 * T_W)'(xt1_r);
      tyy2_r   <= (2 * T_W)'(yt1_r) * (2 * T_W)'(yt1_r);
    end
  end

  // ---------------- stage 3: gradients and fade polynomial ----------------
  logic [ENTRY_W-1:0] h_aa, h_ab, h_ba, h_bb;
  logic signed [OFS_W-1:0] xo0, xo1, yo0, yo1;
  logic signed [GRAD_W-1:0] g_aa, g_ab, g_ba, g_bb;

  assign h_aa = sel_a2_r ? od0 : ev0;
  assign h_ab = sel_a2_r ? ev0 : od0;
  assign h_ba = sel_b2_r ? od1 : ev1;
  assign h_bb = sel_b2_r ? ev1 : od1;

  // Offset t - 1.0 in Q.16 is the fraction with a sign bit set.
  assign xo0 = {1'b0, xt2_r};
  assign xo1 = {1'b1, xt2_r};
  assign yo0 = {1'b0, yt2_r};
  assign yo1 = {1'b1, yt2_r};

  assign g_aa = grad(h_aa, xo0, yo0);
  assign g_ba = grad(h_ba, xo1, yo0);
  assign g_ab = grad(h_ab, xo0, yo1);
  assign g_bb = grad(h_bb, xo1, yo1);

  logic signed [GRAD_W-1:0] gaa3_r, gab3_r;
  logic signed [DIFF_W-1:0] d1_3_r, d2_3_r;
  logic [FADE_P_W-1:0] px3_r, py3_r;
  logic [T_W-1:0] xt3_r, yt3_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      gaa3_r <= g_aa;
      gab3_r <= g_ab;
      d1_3_r <= DIFF_W'(g_ba) - DIFF_W'(g_aa);
      d2_3_r <= DIFF_W'(g_bb) - DIFF_W'(g_ab);
      px3_r  <= fade_p(txx2_r, xt2_r);
      py3_r  <= fade_p(tyy2_r, yt2_r);
      xt3_r  <= xt2_r;
      yt3_r  <= yt2_r;
    end
  end

  // ---------------- stages 4 to 6: fade multiplies ----------------
  logic [FADE_P_W-1:0] rx4_r, ry4_r, rx5_r, ry5_r;
  logic [U_W-1:0] u6_r, v6_r;
  logic [T_W-1:0] xt4_r, yt4_r, xt5_r, yt5_r;
  logic signed [GRAD_W-1:0] gaa4_r, gab4_r, gaa5_r, gab5_r, gaa6_r, gab6_r;
  logic signed [DIFF_W-1:0] d1_4_r, d2_4_r, d1_5_r, d2_5_r, d1_6_r, d2_6_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      rx4_r  <= mul_shift(xt3_r, px3_r);
      ry4_r  <= mul_shift(yt3_r, py3_r);
      xt4_r  <= xt3_r;
      yt4_r  <= yt3_r;
      gaa4_r <= gaa3_r;
      gab4_r <= gab3_r;
      d1_4_r <= d1_3_r;
      d2_4_r <= d2_3_r;
    end
    if (ld[5]) begin
      rx5_r  <= mul_shift(xt4_r, rx4_r);
      ry5_r  <= mul_shift(yt4_r, ry4_r);
      xt5_r  <= xt4_r;
      yt5_r  <= yt4_r;
      gaa5_r <= gaa4_r;
      gab5_r <= gab4_r;
      d1_5_r <= d1_4_r;
      d2_5_r <= d2_4_r;
    end
    if (ld[6]) begin
      u6_r   <= U_W'(mul_shift(xt5_r, rx5_r));
      v6_r   <= U_W'(mul_shift(yt5_r, ry5_r));
      gaa6_r <= gaa5_r;
      gab6_r <= gab5_r;
      d1_6_r <= d1_5_r;
      d2_6_r <= d2_5_r;
    end
  end

  // ---------------- stages 7 to 10: bilinear interpolation ----------------
  logic signed [U_W:0] u_s, v_s;
  logic signed [M_W-1:0] m1, m2, m3;
  logic signed [DIFF_W-1:0] dx9;

  assign u_s = {1'b0, u6_r};

  logic signed [M_W-1:0] m1_7_r, m2_7_r;
  logic signed [GRAD_W-1:0] gaa7_r, gab7_r;
  logic [U_W-1:0] v7_r, v8_r;
  logic signed [GRAD_W-1:0] x1_8_r, x2_8_r, x1_9_r;
  logic signed [M_W-1:0] m3_9_r;

  assign m1  = u_s * d1_6_r;
  assign m2  = u_s * d2_6_r;
  assign v_s = {1'b0, v8_r};
  assign dx9 = DIFF_W'(x2_8_r) - DIFF_W'(x1_8_r);
  assign m3  = v_s * dx9;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      m1_7_r <= m1;
      m2_7_r <= m2;
      gaa7_r <= gaa6_r;
      gab7_r <= gab6_r;
      v7_r   <= v6_r;
    end
    if (ld[8]) begin
      x1_8_r <= GRAD_W'(DIFF_W'(gaa7_r) + DIFF_W'(m1_7_r >>> T_W));
      x2_8_r <= GRAD_W'(DIFF_W'(gab7_r) + DIFF_W'(m2_7_r >>> T_W));
      v8_r   <= v7_r;
    end
    if (ld[9]) begin
      m3_9_r <= m3;
      x1_9_r <= x1_8_r;
    end
  end

  logic signed [DIFF_W-1:0] sum10;
  logic signed [DIFF_W-1:0] quarter10;
  noise_t noise_nxt;
  noise_t noise_r;

  // Final lerp, floor division by four and saturation to Q2.14.
  always_comb begin
    sum10     = DIFF_W'(x1_9_r) + DIFF_W'(m3_9_r >>> T_W);
    quarter10 = sum10 >>> 2;
    if (quarter10 > NOISE_MAX) begin
      noise_nxt = NOISE_W'(NOISE_MAX);
    end else if (quarter10 < NOISE_MIN) begin
      noise_nxt = NOISE_W'(NOISE_MIN);
    end else begin
      noise_nxt = NOISE_W'(quarter10);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      noise_r <= noise_nxt;
    end
  end

  assign out_valid       = v_r[NST];
  assign out_noise_value = noise_r;

  // ---------------- assertions ----------------
  `PN2D_ASSERT_NEXT(a_write_no_entry, clk, rst_n, wr_en, !v_r[1], "write request entered pipe")
  `PN2D_ASSERT_SAME(a_stall_only_full, clk, rst_n, !in_ready, out_valid && !out_ready && (&v_r), "input stalled with room in pipe")
  `PN2D_ASSERT_NEXT(a_last_stage_moves, clk, rst_n, v_r[NST-1] && rdy[NST], out_valid, "result lost before output")

endmodule
